// File: rtl/core/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types, codes and the character pattern table of the Morse encoder.
// ----------------------------------------------------------------------------
package mte_pkg;

    // morse element codes on the output
    typedef enum logic [1:0] {
        SYM_DOT   = 2'd0,
        SYM_DASH  = 2'd1,
        SYM_SPACE = 2'd2
    } sym_t;

    // pair codes, also usable directly as byte values 1 to 5
    localparam logic [2:0] PAIR_NONE = 3'd0;
    localparam logic [2:0] PAIR_AE   = 3'd1;
    localparam logic [2:0] PAIR_OE   = 3'd2;
    localparam logic [2:0] PAIR_UE   = 3'd3;
    localparam logic [2:0] PAIR_CH   = 3'd4;
    localparam logic [2:0] PAIR_SS   = 3'd5;

    // one character pattern: elements before the closing space
    // dash holds the elements first one in the msb, 1 is a dash
    // blank marks the space character, whose one element is a space
    typedef struct packed {
        logic       blank;
        logic [3:0] elems;
        logic [7:0] dash;
    } pat_t;

    // work for one accepted item: an optional flushed or pair pattern,
    // then an optional pattern for the new byte
    typedef struct packed {
        logic first_en;
        pat_t first;
        logic second_en;
        pat_t second;
    } job_t;

    function automatic pat_t mk(input logic [3:0] n, input logic [7:0] d);
        pat_t p;
        p.blank = 1'b0;
        p.elems = n;
        p.dash  = d;
        return p;
    endfunction

    // case folding of upper-case ascii letters
    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b inside {[8'h41:8'h5a]})
            c = b + 8'h20;
        return c;
    endfunction

    function automatic pat_t letter_pat(input logic [4:0] idx);
        pat_t p;
        case (idx)
            5'd0:    p = mk(4'd2, 8'b01000000);
            5'd1:    p = mk(4'd4, 8'b10000000);
            5'd2:    p = mk(4'd4, 8'b10100000);
            5'd3:    p = mk(4'd3, 8'b10000000);
            5'd4:    p = mk(4'd1, 8'b00000000);
            5'd5:    p = mk(4'd4, 8'b00100000);
            5'd6:    p = mk(4'd3, 8'b11000000);
            5'd7:    p = mk(4'd4, 8'b00000000);
            5'd8:    p = mk(4'd2, 8'b00000000);
            5'd9:    p = mk(4'd4, 8'b01110000);
            5'd10:   p = mk(4'd3, 8'b10100000);
            5'd11:   p = mk(4'd4, 8'b01000000);
            5'd12:   p = mk(4'd2, 8'b11000000);
            5'd13:   p = mk(4'd2, 8'b10000000);
            5'd14:   p = mk(4'd3, 8'b11100000);
            5'd15:   p = mk(4'd4, 8'b01100000);
            5'd16:   p = mk(4'd4, 8'b11010000);
            5'd17:   p = mk(4'd3, 8'b01000000);
            5'd18:   p = mk(4'd3, 8'b00000000);
            5'd19:   p = mk(4'd1, 8'b10000000);
            5'd20:   p = mk(4'd3, 8'b00100000);
            5'd21:   p = mk(4'd4, 8'b00010000);
            5'd22:   p = mk(4'd3, 8'b01100000);
            5'd23:   p = mk(4'd4, 8'b10010000);
            5'd24:   p = mk(4'd4, 8'b10110000);
            5'd25:   p = mk(4'd4, 8'b11000000);
            default: p = mk(4'd8, 8'b00000000);
        endcase
        return p;
    endfunction

    function automatic pat_t digit_pat(input logic [3:0] idx);
        pat_t p;
        case (idx)
            4'd0:    p = mk(4'd5, 8'b11111000);
            4'd1:    p = mk(4'd5, 8'b01111000);
            4'd2:    p = mk(4'd5, 8'b00111000);
            4'd3:    p = mk(4'd5, 8'b00011000);
            4'd4:    p = mk(4'd5, 8'b00001000);
            4'd5:    p = mk(4'd5, 8'b00000000);
            4'd6:    p = mk(4'd5, 8'b10000000);
            4'd7:    p = mk(4'd5, 8'b11000000);
            4'd8:    p = mk(4'd5, 8'b11100000);
            4'd9:    p = mk(4'd5, 8'b11110000);
            default: p = mk(4'd8, 8'b00000000);
        endcase
        return p;
    endfunction

    // pattern of one raw byte, closing space not included
    function automatic pat_t pattern_of(input logic [7:0] b);
        logic [7:0] c;
        pat_t       p;
        c = fold(b);
        if (c inside {[8'h61:8'h7a]}) begin
            p = letter_pat(5'(c - 8'h61));
        end
        else if (c inside {[8'h30:8'h39]}) begin
            p = digit_pat(4'(c - 8'h30));
        end
        else begin
            case (c)
                8'h20:   begin
                    p       = mk(4'd1, 8'b00000000);
                    p.blank = 1'b1;
                end
                8'h2e:   p = mk(4'd6, 8'b01010100);   // period
                8'h2c:   p = mk(4'd6, 8'b11001100);   // comma
                8'h3a:   p = mk(4'd6, 8'b11100000);   // colon
                8'h3b:   p = mk(4'd6, 8'b10101000);   // semicolon
                8'h3f:   p = mk(4'd6, 8'b00110000);   // question mark
                8'h2d:   p = mk(4'd6, 8'b10000100);   // hyphen
                8'h5f:   p = mk(4'd6, 8'b00110100);   // underscore
                8'h28:   p = mk(4'd5, 8'b10110000);   // open paren
                8'h29:   p = mk(4'd6, 8'b10110100);   // close paren
                8'h27:   p = mk(4'd6, 8'b01111000);   // apostrophe
                8'h3d:   p = mk(4'd5, 8'b10001000);   // equals
                8'h2b:   p = mk(4'd5, 8'b01010000);   // plus
                8'h2f:   p = mk(4'd5, 8'b10010000);   // slash
                8'h40:   p = mk(4'd6, 8'b01101000);   // at sign
                {5'd0, PAIR_AE}: p = mk(4'd4, 8'b01010000);
                {5'd0, PAIR_OE}: p = mk(4'd4, 8'b11100000);
                {5'd0, PAIR_UE}: p = mk(4'd4, 8'b00110000);
                {5'd0, PAIR_CH}: p = mk(4'd4, 8'b11110000);
                {5'd0, PAIR_SS}: p = mk(4'd7, 8'b00011000);
                default: p = mk(4'd8, 8'b00000000);   // unknown byte
            endcase
        end
        return p;
    endfunction

endpackage

// File: rtl/core/mte_decode.sv
// ----------------------------------------------------------------------------
// mte_decode
// Pair detection and pattern lookup for one byte against the held starter.
// ----------------------------------------------------------------------------
module mte_decode (
    input  logic              held_valid,
    input  logic [7:0]        held_char,
    input  logic [7:0]        char_code,
    input  logic              end_of_text,
    output mte_pkg::job_t     job,
    output logic              job_any,
    output logic              held_valid_next,
    output logic [7:0]        held_char_next
);

    logic [7:0] held_fold;
    logic [7:0] new_fold;
    logic [2:0] pair;
    logic       starter;

    // case-folded views of both bytes
    assign held_fold = mte_pkg::fold(held_char);
    assign new_fold  = mte_pkg::fold(char_code);

    // new byte could open a pair
    assign starter = (new_fold == 8'h61) || (new_fold == 8'h6f) || (new_fold == 8'h75)
                  || (new_fold == 8'h63) || (new_fold == 8'h73);

    // pair code of held starter and new byte
    always_comb
    begin
        pair = mte_pkg::PAIR_NONE;
        if (new_fold == 8'h65) begin
            if (held_fold == 8'h61)
                pair = mte_pkg::PAIR_AE;
            else if (held_fold == 8'h6f)
                pair = mte_pkg::PAIR_OE;
            else if (held_fold == 8'h75)
                pair = mte_pkg::PAIR_UE;
        end
        if ((held_fold == 8'h63) && (new_fold == 8'h68))
            pair = mte_pkg::PAIR_CH;
        if ((held_fold == 8'h73) && (new_fold == 8'h73))
            pair = mte_pkg::PAIR_SS;
    end

    // build the job and the next hold state
    always_comb
    begin
        job.first_en    = 1'b0;
        job.first       = mte_pkg::pattern_of(held_char);
        job.second_en   = 1'b0;
        job.second      = mte_pkg::pattern_of(char_code);
        held_valid_next = 1'b0;
        held_char_next  = held_char;
        if (held_valid && (pair != mte_pkg::PAIR_NONE)) begin
            job.first_en = 1'b1;
            job.first    = mte_pkg::pattern_of({5'd0, pair});
        end
        else begin
            job.first_en = held_valid;
            if (!end_of_text && starter) begin
                held_valid_next = 1'b1;
                held_char_next  = char_code;
            end
            else begin
                job.second_en = 1'b1;
            end
        end
    end

    assign job_any = job.first_en || job.second_en;

endmodule

// File: rtl/core/mte_emitter.sv
// ----------------------------------------------------------------------------
// mte_emitter
// Job register and symbol serializer with a registered stream output.
// ----------------------------------------------------------------------------
module mte_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  mte_pkg::job_t     job,
    output logic              m_tvalid,
    input  logic              m_tready,
    output mte_pkg::sym_t     sym,
    output logic              m_tlast
);

    logic          job_valid_reg;
    logic          job_valid_next;
    mte_pkg::job_t job_reg;
    logic          phase_reg;
    logic          phase_next;
    logic [3:0]    idx_reg;
    logic [3:0]    idx_next;
    logic          m_tvalid_reg;
    logic          m_tvalid_next;
    mte_pkg::sym_t sym_reg;
    logic          m_tlast_reg;

    mte_pkg::pat_t cur;
    mte_pkg::sym_t cur_sym;
    logic          pat_end;
    logic          job_last;
    logic          out_load;

    // current pattern and element
    assign cur      = phase_reg ? job_reg.second : job_reg.first;
    assign pat_end  = (idx_reg == cur.elems);
    assign job_last = pat_end && (phase_reg || !job_reg.second_en);

    always_comb
    begin
        if (pat_end || cur.blank)
            cur_sym = mte_pkg::SYM_SPACE;
        else if (cur.dash[3'd7 - idx_reg[2:0]])
            cur_sym = mte_pkg::SYM_DASH;
        else
            cur_sym = mte_pkg::SYM_DOT;
    end

    // output register takes a symbol when empty or being drained
    assign out_load  = job_valid_reg && (!m_tvalid_reg || m_tready);
    assign job_ready = !job_valid_reg || (out_load && job_last);

    // next state of the walk through the job
    always_comb
    begin
        job_valid_next = job_valid_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        m_tvalid_next  = m_tvalid_reg;
        if (m_tready)
            m_tvalid_next = 1'b0;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            if (pat_end) begin
                phase_next = 1'b1;
                idx_next   = 4'd0;
            end
            else begin
                idx_next = idx_reg + 4'd1;
            end
        end
        if (job_ready) begin
            job_valid_next = job_valid;
            phase_next     = !job.first_en;
            idx_next       = 4'd0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            job_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            idx_reg       <= 4'd0;
            m_tvalid_reg  <= 1'b0;
        end
        else begin
            job_valid_reg <= job_valid_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (job_ready)
            job_reg <= job;
        if (out_load) begin
            sym_reg     <= cur_sym;
            m_tlast_reg <= job_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign sym      = sym_reg;
    assign m_tlast  = m_tlast_reg;

    // element index never runs past the closing space
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (idx_reg <= cur.elems))
        else $error("element index past end of pattern");

    // second phase only exists when the job has a second pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && phase_reg) |-> job_reg.second_en)
        else $error("second phase without second pattern");

    // a held job always carries at least one pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_reg.first_en || job_reg.second_en))
        else $error("empty job held");

    // every item closes on a space
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tlast_reg) |-> (sym_reg == mte_pkg::SYM_SPACE))
        else $error("final symbol of an item is not a space");

endmodule

// File: rtl/core/morse_text_encoder.sv
// ----------------------------------------------------------------------------
// morse_text_encoder
// Streaming text to Morse element encoder with German pair substitution.
// ----------------------------------------------------------------------------
// Each input byte is decoded in the cycle it is accepted and its symbols leave
// one per cycle from a registered output unless the receiver stalls; each
// character is its elements plus one space, and a flushed starter adds its own
// pattern in front. A starter a, o, u, c or s that is not the final byte and
// completes no pair emits nothing itself. The one-symbol-per-cycle serializer
// sets the rate; the next byte is accepted in the cycle the final symbol of
// the previous one is loaded: no gaps while the receiver is ready and no
// starter is held. Output tdata carries element code 0 dot, 1 dash, 2 space.
// ----------------------------------------------------------------------------
module morse_text_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] char_code
    input  logic       s_tlast,     // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [1:0] symbol, [7:2] zero
    output logic       m_tlast      // last
);

    logic          held_valid_reg;
    logic          held_valid_next;
    logic [7:0]    held_char_reg;
    logic [7:0]    held_char_next;
    mte_pkg::job_t job;
    logic          job_any;
    logic          job_ready;
    logic          in_accept;
    mte_pkg::sym_t sym;

    assign s_tready  = job_ready;
    assign in_accept = s_tvalid && job_ready;

    // pair detection and pattern lookup
    mte_decode u_decode (
        .held_valid      (held_valid_reg),
        .held_char       (held_char_reg),
        .char_code       (s_tdata),
        .end_of_text     (s_tlast),
        .job             (job),
        .job_any         (job_any),
        .held_valid_next (held_valid_next),
        .held_char_next  (held_char_next)
    );

    // held starter character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_valid_reg <= 1'b0;
            held_char_reg  <= 8'd0;
        end
        else if (in_accept) begin
            held_valid_reg <= held_valid_next;
            held_char_reg  <= held_char_next;
        end
    end

    // symbol serializer
    mte_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (s_tvalid && job_any),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .sym       (sym),
        .m_tlast   (m_tlast)
    );

    assign m_tdata = {6'd0, sym};

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for morse_text_encoder: text bytes go in on the slave
// stream, and each Morse element coming out is checked against a predictor
// that keeps its own copy of the held pair starter.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 25;

    // one expected output element
    typedef struct packed {
        mte_pkg::sym_t symbol;
        logic          last;
    } morse_elem_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;    // [7:0] char_code
    logic       s_tlast  = 1'b0;    // end_of_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [1:0] symbol, [7:2] zero
    logic       m_tlast;            // last

    // predictor state: the starter held back while waiting for its partner
    logic       hold_valid = 1'b0;
    logic [7:0] hold_char  = 8'd0;

    morse_elem_t pending_elems[$];
    int          err_count  = 0;
    int          quiet_cycles = 0;
    bit          idle_on    = 1'b1;
    bit          hold_req   = 1'b0;
    int          hold_left  = 0;
    int          stall_left = 0;

    morse_text_encoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] b);
        if (b >= "A" && b <= "Z")
            return b + 8'd32;
        return b;
    endfunction

    // elements of one character, closing space not included
    function automatic string elements_of(input logic [7:0] raw);
        case (lower_case(raw))
            "a": return ".-";
            "b": return "-...";
            "c": return "-.-.";
            "d": return "-..";
            "e": return ".";
            "f": return "..-.";
            "g": return "--.";
            "h": return "....";
            "i": return "..";
            "j": return ".---";
            "k": return "-.-";
            "l": return ".-..";
            "m": return "--";
            "n": return "-.";
            "o": return "---";
            "p": return ".--.";
            "q": return "--.-";
            "r": return ".-.";
            "s": return "...";
            "t": return "-";
            "u": return "..-";
            "v": return "...-";
            "w": return ".--";
            "x": return "-..-";
            "y": return "-.--";
            "z": return "--..";
            "0": return "-----";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            " ": return " ";
            ".": return ".-.-.-";
            ",": return "--..--";
            ":": return "---...";
            ";": return "-.-.-.";
            "?": return "..--..";
            "-": return "-....-";
            "_": return "..--.-";
            "(": return "-.--.";
            ")": return "-.--.-";
            "'": return ".----.";
            "=": return "-...-";
            "+": return ".-.-.";
            "/": return "-..-.";
            "@": return ".--.-.";
            {5'd0, mte_pkg::PAIR_AE}: return ".-.-";
            {5'd0, mte_pkg::PAIR_OE}: return "---.";
            {5'd0, mte_pkg::PAIR_UE}: return "..--";
            {5'd0, mte_pkg::PAIR_CH}: return "----";
            {5'd0, mte_pkg::PAIR_SS}: return "...--..";
            default: return "........";
        endcase
    endfunction

    function automatic bit is_starter(input logic [7:0] b);
        logic [7:0] c;
        c = lower_case(b);
        return c == "a" || c == "o" || c == "u" || c == "c" || c == "s";
    endfunction

    function automatic logic [2:0] pair_of(input logic [7:0] first,
                                           input logic [7:0] second);
        logic [7:0] a;
        logic [7:0] b;
        a = lower_case(first);
        b = lower_case(second);
        if (b == "e" && a == "a") return mte_pkg::PAIR_AE;
        if (b == "e" && a == "o") return mte_pkg::PAIR_OE;
        if (b == "e" && a == "u") return mte_pkg::PAIR_UE;
        if (a == "c" && b == "h") return mte_pkg::PAIR_CH;
        if (a == "s" && b == "s") return mte_pkg::PAIR_SS;
        return mte_pkg::PAIR_NONE;
    endfunction

    // work out the elements one accepted byte causes and queue them
    task automatic predict_elements(input logic [7:0] c, input logic eot);
        string       seq;
        logic [2:0]  pc;
        bit          paired;
        morse_elem_t e;
        seq    = "";
        paired = 1'b0;
        // a held starter either completes a pair or is flushed first
        if (hold_valid) begin
            pc         = pair_of(hold_char, c);
            hold_valid = 1'b0;
            if (pc != mte_pkg::PAIR_NONE) begin
                seq    = {elements_of({5'd0, pc}), " "};
                paired = 1'b1;
            end
            else begin
                seq = {elements_of(hold_char), " "};
            end
        end
        if (!paired) begin
            if (!eot && is_starter(c)) begin
                hold_valid = 1'b1;
                hold_char  = c;
            end
            else begin
                seq = {seq, elements_of(c), " "};
            end
        end
        for (int i = 0; i < seq.len(); i++) begin
            if (seq[i] == ".")
                e.symbol = mte_pkg::SYM_DOT;
            else if (seq[i] == "-")
                e.symbol = mte_pkg::SYM_DASH;
            else
                e.symbol = mte_pkg::SYM_SPACE;
            e.last   = (i == seq.len() - 1);
            pending_elems.push_back(e);
        end
    endtask

    // offer one item after a random gap and wait for it to be taken
    task automatic send_item(input logic [7:0] c, input logic eot);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_elements(c, eot);
    endtask

    task automatic send_text(input string s, input bit eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], eot_at_end && (i == s.len() - 1));
    endtask

    // character mix weighted toward pair starters and partners
    function automatic logic [7:0] pick_char();
        string pairish;
        string charset;
        int    r;
        pairish = "aouAOUcCsSeEhH";
        charset = {"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ",
                   "0123456789 .,:;?-_()'=+/@"};
        r = $urandom_range(0, 99);
        if (r < 40)
            return pairish[$urandom_range(0, pairish.len() - 1)];
        if (r < 75)
            return charset[$urandom_range(0, charset.len() - 1)];
        if (r < 85)
            return 8'($urandom_range(1, 5));
        return 8'($urandom_range(0, 255));
    endfunction

    // random texts, each closed by end_of_text, with stray ends mixed in
    task automatic send_random_texts(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len && sent < count; k++) begin
                send_item(pick_char(), (k == len - 1) || ($urandom_range(0, 19) == 0));
                sent++;
            end
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // compare each output item with the oldest expectation, and watchdog
    always @(posedge clk)
    begin
        morse_elem_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (pending_elems.size() == 0) begin
                    $error("unexpected element: symbol %0d last %0b", m_tdata[1:0], m_tlast);
                    err_count++;
                end
                else begin
                    want = pending_elems.pop_front();
                    if (m_tdata[1:0] !== want.symbol) begin
                        $error("symbol: expected %0d, actual %0d", want.symbol, m_tdata[1:0]);
                        err_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        err_count++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $error("tdata padding: expected 0, actual %0h", m_tdata[7:2]);
                        err_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // pairs, pair failures, flushes, direct pair bytes, extremes
    task automatic test_directed();
        idle_on = 1'b1;
        send_text("AeoEUeChsS", 1'b0);
        send_text("aox", 1'b0);
        // flushed starter followed by an unknown byte gives the longest burst
        send_item("c", 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item({5'd0, mte_pkg::PAIR_AE}, 1'b0);
        send_item({5'd0, mte_pkg::PAIR_OE}, 1'b0);
        send_item({5'd0, mte_pkg::PAIR_UE}, 1'b0);
        send_item({5'd0, mte_pkg::PAIR_CH}, 1'b0);
        send_item({5'd0, mte_pkg::PAIR_SS}, 1'b0);
        send_text(" 6789", 1'b0);
        // starter on the final byte is encoded at once
        send_item("u", 1'b1);
        // pair still completes when its partner is the final byte
        send_text("aE", 1'b1);
        send_text("se", 1'b1);
    endtask

    task automatic test_random_bursty(input int count);
        idle_on = 1'b1;
        send_random_texts(count);
    endtask

    task automatic test_random_steady(input int count);
        idle_on = 1'b0;
        send_random_texts(count);
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req <= 1'b1;
        send_random_texts(60);
        idle_on  = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_bursty(200);
        test_random_steady(80);
        test_backpressure();
        test_random_bursty(60);
        s_tvalid <= 1'b0;
        // drain, then give the block time to show any stray output
        while (pending_elems.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_elems.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
